### src/dtpv_pkg.sv
`default_nettype none

package dtpv_pkg;

  // Field and datapath widths.
  localparam int RAW_W      = 16;
  localparam int DIST_W     = 12;
  localparam int FRAC_BITS  = 8;
  localparam int NUM_W      = DIST_W + FRAC_BITS;
  localparam int RATIO_W    = FRAC_BITS + 1;
  localparam int HZ_W       = 11;
  localparam int LEVEL_W    = 8;
  localparam int FREQ_W     = 20;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COUNT_W;

  // A raw reading at or above this value is rejected.
  localparam int DIST_LIMIT = 4096;

  localparam logic [COUNT_W-1:0] FAIL_LIMIT_RESET = COUNT_W'(50);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET      = LEVEL_W'(128);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUAL_MODE  = 1'b0,
    REG_FAIL_LIMIT = 1'b1
  } cfg_reg_e;

  // One request: a pair of sensor readings.
  typedef struct packed {
    logic [RAW_W-1:0] pitch_reading;
    logic             pitch_timed_out;
    logic [RAW_W-1:0] volume_reading;
    logic             volume_timed_out;
  } sample_t;

  // One result.
  typedef struct packed {
    logic [HZ_W-1:0]    pitch_hz;
    logic [LEVEL_W-1:0] volume_level;
    logic               mute;
    logic               restart_pitch_sensor;
    logic               restart_volume_sensor;
    logic [DIST_W-1:0]  pitch_distance;
    logic [DIST_W-1:0]  volume_distance;
  } result_t;

  // Per-item information that travels alongside the ratio lanes.
  typedef struct packed {
    logic              pitch_in;
    logic              volume_in;
    logic              restart_pitch;
    logic              restart_volume;
    logic [DIST_W-1:0] pitch_distance;
    logic [DIST_W-1:0] volume_distance;
  } side_t;

  // Stage load strobes for a ratio lane.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

endpackage

`default_nettype wire

### src/dtpv_track.sv
`default_nettype none

module dtpv_track
  import dtpv_pkg::*;
#(
  parameter int MIN_DIST = 30,
  parameter int MAX_DIST = 450
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load0,
  input  logic                  load1,
  input  sample_t               sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output side_t                 side,
  output logic [DIST_W-1:0]     x_pitch,
  output logic [DIST_W-1:0]     x_volume
);

  localparam logic [DIST_W-1:0] MIN_D = DIST_W'(MIN_DIST);
  localparam logic [DIST_W-1:0] MAX_D = DIST_W'(MAX_DIST);

  function automatic logic in_span(input logic [DIST_W-1:0] d);
    return (d >= MIN_D) && (d <= MAX_D);
  endfunction

  sample_t            s0;
  logic               dual_mode;
  logic [COUNT_W-1:0] fail_limit;

  logic [DIST_W-1:0]  held_pitch_dist, held_pitch_dist_next;
  logic [DIST_W-1:0]  held_volume_dist, held_volume_dist_next;
  logic [COUNT_W-1:0] pitch_fail_count, pitch_fail_count_next;
  logic [COUNT_W-1:0] volume_fail_count, volume_fail_count_next;
  logic               restart_pitch, restart_pitch_next;
  logic               restart_volume, restart_volume_next;
  logic               pitch_in, volume_in;

  logic               pitch_ok, volume_ok;
  logic [COUNT_W:0]   pitch_inc, volume_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dual_mode  <= 1'b0;
      fail_limit <= FAIL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_DUAL_MODE:  dual_mode  <= cfg_data[0];
        REG_FAIL_LIMIT: fail_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (load0) begin
      s0 <= sample;
    end
  end

  // Reading acceptance and fail counting for both sensors.
  always_comb begin
    pitch_ok  = !s0.pitch_timed_out && (s0.pitch_reading < RAW_W'(DIST_LIMIT));
    volume_ok = !s0.volume_timed_out && (s0.volume_reading < RAW_W'(DIST_LIMIT));
    pitch_inc  = {1'b0, pitch_fail_count} + (COUNT_W+1)'(1);
    volume_inc = {1'b0, volume_fail_count} + (COUNT_W+1)'(1);

    held_pitch_dist_next  = held_pitch_dist;
    pitch_fail_count_next = pitch_fail_count;
    restart_pitch_next    = 1'b0;
    if (pitch_ok) begin
      held_pitch_dist_next  = s0.pitch_reading[DIST_W-1:0];
      pitch_fail_count_next = '0;
    end else if (pitch_inc > {1'b0, fail_limit}) begin
      pitch_fail_count_next = '0;
      restart_pitch_next    = 1'b1;
    end else begin
      pitch_fail_count_next = pitch_inc[COUNT_W-1:0];
    end

    held_volume_dist_next  = held_volume_dist;
    volume_fail_count_next = volume_fail_count;
    restart_volume_next    = 1'b0;
    if (!dual_mode) begin
      held_volume_dist_next = held_pitch_dist_next;
    end else if (volume_ok) begin
      held_volume_dist_next  = s0.volume_reading[DIST_W-1:0];
      volume_fail_count_next = '0;
    end else if (volume_inc > {1'b0, fail_limit}) begin
      volume_fail_count_next = '0;
      restart_volume_next    = 1'b1;
    end else begin
      volume_fail_count_next = volume_inc[COUNT_W-1:0];
    end
  end

  // Held state doubles as the stage register for the distances.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pitch_dist   <= '0;
      held_volume_dist  <= '0;
      pitch_fail_count  <= '0;
      volume_fail_count <= '0;
      restart_pitch     <= 1'b0;
      restart_volume    <= 1'b0;
      pitch_in          <= 1'b0;
      volume_in         <= 1'b0;
    end else if (load1) begin
      held_pitch_dist   <= held_pitch_dist_next;
      held_volume_dist  <= held_volume_dist_next;
      pitch_fail_count  <= pitch_fail_count_next;
      volume_fail_count <= volume_fail_count_next;
      restart_pitch     <= restart_pitch_next;
      restart_volume    <= restart_volume_next;
      pitch_in          <= in_span(held_pitch_dist_next);
      volume_in         <= in_span(held_volume_dist_next);
    end
  end

  // Distance from the far end of the span, the divider's numerator.
  always_ff @(posedge clk) begin
    if (load1) begin
      x_pitch  <= MAX_D - held_pitch_dist_next;
      x_volume <= MAX_D - held_volume_dist_next;
    end
  end

  always_comb begin
    side.pitch_in        = pitch_in;
    side.volume_in       = volume_in;
    side.restart_pitch   = restart_pitch;
    side.restart_volume  = restart_volume;
    side.pitch_distance  = held_pitch_dist;
    side.volume_distance = held_volume_dist;
  end

  // A restart pulse always comes with a cleared count.
  a_restart_clears_pitch: assert property (@(posedge clk) disable iff (rst)
    restart_pitch |-> (pitch_fail_count == '0))
    else $error("pitch restart without cleared count");

  // In single-sensor mode the volume distance follows pitch and never restarts.
  a_single_mode_copy: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(load1) && !$past(dual_mode)) |->
      (!restart_volume && (held_volume_dist == held_pitch_dist)))
    else $error("single-sensor copy broken");

endmodule

`default_nettype wire

### src/dtpv_ratio.sv
`default_nettype none

module dtpv_ratio
  import dtpv_pkg::*;
#(
  parameter int MIN_DIST = 30,
  parameter int MAX_DIST = 450
) (
  input  logic               clk,
  input  logic               rst,
  input  lane_en_t           en,
  input  logic [DIST_W-1:0]  x,
  output logic [RATIO_W-1:0] ratio
);

  localparam int RECIP_W = NUM_W + 1;
  localparam int PROD_W  = DIST_W + RECIP_W;
  localparam int QS_W    = RATIO_W + DIST_W;
  localparam int SPAN     = MAX_DIST - MIN_DIST;
  localparam int SpanDiv  = (SPAN > 0) ? SPAN : 1;
  localparam bit EMPTY    = (SPAN <= 0);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((1 << NUM_W) / SpanDiv);
  localparam logic [DIST_W-1:0]  SPAN_C = DIST_W'(SpanDiv);
  localparam logic [RATIO_W-1:0] RATIO_FULL = RATIO_W'(1 << FRAC_BITS);

  logic [PROD_W-1:0]  prod2;
  logic [DIST_W-1:0]  x2;
  logic [RATIO_W-1:0] q_est, q_est3;
  logic [QS_W-1:0]    qs_full;
  logic [NUM_W-1:0]   qs3, n3, rem;

  // Reciprocal multiply: x * 2^FRAC_BITS / span, low by at most one.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod2 <= PROD_W'(x) * PROD_W'(RECIP);
      x2    <= x;
    end
  end

  assign q_est   = prod2[DIST_W +: RATIO_W];
  assign qs_full = QS_W'(q_est) * QS_W'(SPAN_C);

  // Estimate times span, to form the remainder.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      q_est3 <= q_est;
      qs3    <= qs_full[NUM_W-1:0];
      n3     <= {x2, {FRAC_BITS{1'b0}}};
    end
  end

  assign rem = n3 - qs3;

  // Correction step; an empty span always gives the full ratio.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (EMPTY) begin
        ratio <= RATIO_FULL;
      end else begin
        ratio <= q_est3 + RATIO_W'(rem >= NUM_W'(SPAN_C));
      end
    end
  end

  // For a distance inside the span, the estimate never overshoots and its
  // remainder stays below two spans.
  a_estimate_bound: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(en.s3) && (n3[NUM_W-1:FRAC_BITS] <= SPAN_C)) |->
      ((qs3 <= n3) && ({1'b0, rem} < (NUM_W+1)'(2 * SpanDiv))))
    else $error("reciprocal estimate out of bounds");

endmodule

`default_nettype wire

### src/dtpv_smooth.sv
`default_nettype none

module dtpv_smooth
  import dtpv_pkg::*;
#(
  parameter int MIN_FREQ = 65,
  parameter int MAX_FREQ = 2000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  side_t              side,
  input  logic [RATIO_W-1:0] ratio_pitch,
  input  logic [RATIO_W-1:0] ratio_volume,
  output result_t            result
);

  localparam int TW = FREQ_W + 2;
  localparam int LW = RATIO_W + FRAC_BITS;
  localparam int LO_HZ = (MIN_FREQ < MAX_FREQ) ? MIN_FREQ : MAX_FREQ;
  localparam int HI_HZ = (MIN_FREQ < MAX_FREQ) ? MAX_FREQ : MIN_FREQ;
  localparam logic signed [TW-1:0] DELTA_F   = TW'(MAX_FREQ - MIN_FREQ);
  localparam logic signed [TW-1:0] BASE_F    = TW'(MIN_FREQ * (1 << FRAC_BITS));
  localparam logic [FREQ_W-1:0]    FREQ_INIT = FREQ_W'(MIN_FREQ * (1 << FRAC_BITS));
  localparam logic [FREQ_W-1:0]    FREQ_LO   = FREQ_W'(LO_HZ * (1 << FRAC_BITS));
  localparam logic [FREQ_W-1:0]    FREQ_HI   = FREQ_W'(HI_HZ * (1 << FRAC_BITS));

  logic [FREQ_W-1:0]     freq_accum, freq_accum_next;
  logic [LEVEL_W-1:0]    held_volume;
  logic                  mute_flag;
  side_t                 side_q;

  logic signed [TW-1:0]  ratio_s, target, diff, half;
  logic [LW-1:0]         level_wide;

  // Target frequency and the halfway step, rounding toward minus infinity.
  always_comb begin
    ratio_s = $signed(TW'(ratio_pitch));
    target  = BASE_F + ratio_s * DELTA_F;
    diff    = target - $signed({2'b00, freq_accum});
    half    = diff >>> 1;
    freq_accum_next = freq_accum + half[FREQ_W-1:0];
  end

  // Volume is ratio * 255 / 256.
  assign level_wide = {ratio_volume, {FRAC_BITS{1'b0}}} - LW'(ratio_volume);

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_accum  <= FREQ_INIT;
      held_volume <= LEVEL_RESET;
      mute_flag   <= 1'b1;
      side_q      <= '0;
    end else if (load) begin
      side_q <= side;
      if (side.pitch_in) begin
        freq_accum <= freq_accum_next;
      end
      if (side.volume_in) begin
        held_volume <= level_wide[FRAC_BITS +: LEVEL_W];
        mute_flag   <= 1'b0;
      end else begin
        mute_flag <= 1'b1;
      end
    end
  end

  always_comb begin
    result.pitch_hz              = freq_accum[FRAC_BITS +: HZ_W];
    result.volume_level          = held_volume;
    result.mute                  = mute_flag;
    result.restart_pitch_sensor  = side_q.restart_pitch;
    result.restart_volume_sensor = side_q.restart_volume;
    result.pitch_distance        = side_q.pitch_distance;
    result.volume_distance       = side_q.volume_distance;
  end

  // Halfway steps keep the frequency between the two ends of the map.
  a_freq_bounded: assert property (@(posedge clk) disable iff (rst)
    (freq_accum >= FREQ_LO) && (freq_accum <= FREQ_HI))
    else $error("smoothed frequency left the map range");

endmodule

`default_nettype wire

### src/distance_to_pitch_volume.sv
// Throughput: one request per cycle while result_stall is low; six register
// stages (input, reading tracking, reciprocal multiply, remainder, correction,
// smoothing/output) each move on whenever the stage after them is free or
// draining.
// Reset (rst, synchronous): pipeline empty, single-sensor mode, fail limit 50,
// frequency MIN_FREQ Hz, volume 128 and muted, distances and fail counts zero.
`default_nettype none

module distance_to_pitch_volume
  import dtpv_pkg::*;
#(
  parameter int MIN_DIST = 30,
  parameter int MAX_DIST = 450,
  parameter int MIN_FREQ = 65,
  parameter int MAX_FREQ = 2000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 6;

  logic [NSTG-1:0]    vld, rdy, load, vin;
  lane_en_t           lane_en;
  side_t              side1, side2, side3, side4;
  logic [DIST_W-1:0]  x_pitch, x_volume;
  logic [RATIO_W-1:0] ratio_pitch, ratio_volume;

  // Stage ready chain: a stage takes new data when empty or moving on.
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !result_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vin  = {vld[NSTG-2:0], sample_valid};
    load = rdy & vin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy & vin) | (~rdy & vld);
    end
  end

  assign sample_stall = !rdy[0];
  assign result_valid = vld[NSTG-1];
  assign cfg_ready    = 1'b1;

  assign lane_en.s2 = load[2];
  assign lane_en.s3 = load[3];
  assign lane_en.s4 = load[4];

  dtpv_track #(
    .MIN_DIST (MIN_DIST),
    .MAX_DIST (MAX_DIST)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .load0     (load[0]),
    .load1     (load[1]),
    .sample    (sample),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .side      (side1),
    .x_pitch   (x_pitch),
    .x_volume  (x_volume)
  );

  dtpv_ratio #(
    .MIN_DIST (MIN_DIST),
    .MAX_DIST (MAX_DIST)
  ) u_ratio_pitch (
    .clk   (clk),
    .rst   (rst),
    .en    (lane_en),
    .x     (x_pitch),
    .ratio (ratio_pitch)
  );

  dtpv_ratio #(
    .MIN_DIST (MIN_DIST),
    .MAX_DIST (MAX_DIST)
  ) u_ratio_volume (
    .clk   (clk),
    .rst   (rst),
    .en    (lane_en),
    .x     (x_volume),
    .ratio (ratio_volume)
  );

  // Side information follows the ratio lanes stage for stage.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      side2 <= side1;
    end
    if (load[3]) begin
      side3 <= side2;
    end
    if (load[4]) begin
      side4 <= side3;
    end
  end

  dtpv_smooth #(
    .MIN_FREQ (MIN_FREQ),
    .MAX_FREQ (MAX_FREQ)
  ) u_smooth (
    .clk          (clk),
    .rst          (rst),
    .load         (load[NSTG-1]),
    .side         (side4),
    .ratio_pitch  (ratio_pitch),
    .ratio_volume (ratio_volume),
    .result       (result)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top
  import dtpv_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_DIST = 30;
  localparam int MAX_DIST = 450;
  localparam int MIN_FREQ = 65;
  localparam int MAX_FREQ = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 125;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DUAL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Readings waiting to be sent and results predicted for accepted requests.
  sample_t reading_queue[$];
  result_t predicted_q[$];
  int      error_count = 0;
  int      gap_left = 0;
  int      stall_left = 0;

  // Local copy of the mapper's registers and state.
  logic               mdl_dual;
  logic [COUNT_W-1:0] mdl_fail_limit;
  longint             mdl_freq;
  logic [DIST_W-1:0]  mdl_pitch_dist;
  logic [DIST_W-1:0]  mdl_volume_dist;
  logic [LEVEL_W-1:0] mdl_volume;
  logic               mdl_mute;
  logic [COUNT_W-1:0] mdl_pitch_fails;
  logic [COUNT_W-1:0] mdl_volume_fails;

  distance_to_pitch_volume #(
    .MIN_DIST(MIN_DIST),
    .MAX_DIST(MAX_DIST),
    .MIN_FREQ(MIN_FREQ),
    .MAX_FREQ(MAX_FREQ)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Accept or reject one reading; returns 1 when a restart pulse is due.
  function automatic logic track_reading(input logic [RAW_W-1:0] raw, input logic tmo,
                                         inout logic [DIST_W-1:0] held,
                                         inout logic [COUNT_W-1:0] fails);
    if (!tmo && raw < DIST_LIMIT) begin
      held = raw[DIST_W-1:0];
      fails = '0;
      return 1'b0;
    end
    if (int'(fails) + 1 > int'(mdl_fail_limit)) begin
      fails = '0;
      return 1'b1;
    end
    fails = fails + 1'b1;
    return 1'b0;
  endfunction

  function automatic logic dist_in_range(logic [DIST_W-1:0] d);
    return int'(d) >= MIN_DIST && int'(d) <= MAX_DIST;
  endfunction

  // Distance as a fraction of the span from the far end, 8 fraction bits.
  function automatic longint span_fraction(logic [DIST_W-1:0] d);
    longint span;
    span = longint'(MAX_DIST) - longint'(MIN_DIST);
    if (span <= 0) return longint'(1) << FRAC_BITS;
    return ((longint'(MAX_DIST) - longint'(d)) * (longint'(1) << FRAC_BITS)) / span;
  endfunction

  // Advance the local state by one reading pair and form the result.
  function automatic result_t predict_mapping(sample_t s);
    result_t r;
    logic    rp;
    logic    rv;
    longint  ratio;
    longint  target;
    longint  diff;
    longint  half;
    rv = 1'b0;
    rp = track_reading(s.pitch_reading, s.pitch_timed_out, mdl_pitch_dist, mdl_pitch_fails);
    if (mdl_dual)
      rv = track_reading(s.volume_reading, s.volume_timed_out, mdl_volume_dist,
                         mdl_volume_fails);
    else
      mdl_volume_dist = mdl_pitch_dist;

    if (dist_in_range(mdl_pitch_dist)) begin
      ratio = span_fraction(mdl_pitch_dist);
      target = (longint'(MIN_FREQ) << FRAC_BITS) + ratio * (MAX_FREQ - MIN_FREQ);
      diff = target - mdl_freq;
      // Halve, rounding toward minus infinity.
      half = (diff >= 0) ? diff / 2 : -((-diff + 1) / 2);
      mdl_freq = mdl_freq + half;
    end

    if (dist_in_range(mdl_volume_dist)) begin
      ratio = span_fraction(mdl_volume_dist);
      mdl_volume = LEVEL_W'((ratio * 255) / 256);
      mdl_mute = 1'b0;
    end else begin
      mdl_mute = 1'b1;
    end

    r.pitch_hz = HZ_W'(mdl_freq >> FRAC_BITS);
    r.volume_level = mdl_volume;
    r.mute = mdl_mute;
    r.restart_pitch_sensor = rp;
    r.restart_volume_sensor = rv;
    r.pitch_distance = mdl_pitch_dist;
    r.volume_distance = mdl_volume_dist;
    return r;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver: presents queued readings and predicts each accepted one.
  always @(posedge clk) begin : driver
    int  g;
    logic taken;
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      taken = sample_valid && !sample_stall;
      g = gap_left;
      if (taken) begin
        predicted_q.push_back(predict_mapping(sample));
        g = pick_gap();
      end
      if (!sample_valid || taken) begin
        if (g > 0) begin
          sample_valid <= 1'b0;
          gap_left <= g - 1;
        end else if (reading_queue.size() > 0) begin
          sample <= reading_queue.pop_front();
          sample_valid <= 1'b1;
          gap_left <= 0;
        end else begin
          sample_valid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // Result monitor: checks accepted results and stalls at random.
  always @(posedge clk) begin : monitor
    result_t want;
    int roll;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_q.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = predicted_q.pop_front();
          if (result.pitch_hz !== want.pitch_hz)
            report_error($sformatf("pitch_hz got %0d want %0d",
                                   result.pitch_hz, want.pitch_hz));
          if (result.volume_level !== want.volume_level)
            report_error($sformatf("volume_level got %0d want %0d",
                                   result.volume_level, want.volume_level));
          if (result.mute !== want.mute)
            report_error($sformatf("mute got %0b want %0b", result.mute, want.mute));
          if (result.restart_pitch_sensor !== want.restart_pitch_sensor)
            report_error($sformatf("restart_pitch_sensor got %0b want %0b",
                                   result.restart_pitch_sensor, want.restart_pitch_sensor));
          if (result.restart_volume_sensor !== want.restart_volume_sensor)
            report_error($sformatf("restart_volume_sensor got %0b want %0b",
                                   result.restart_volume_sensor,
                                   want.restart_volume_sensor));
          if (result.pitch_distance !== want.pitch_distance)
            report_error($sformatf("pitch_distance got %0d want %0d",
                                   result.pitch_distance, want.pitch_distance));
          if (result.volume_distance !== want.volume_distance)
            report_error($sformatf("volume_distance got %0d want %0d",
                                   result.volume_distance, want.volume_distance));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          result_stall <= 1'b0;
          stall_left <= $urandom_range(0, 8);
        end else if (roll < 90) begin
          result_stall <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end else begin
          result_stall <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic sample_t make_pair(int p, logic pt, int v, logic vt);
    sample_t s;
    s.pitch_reading = RAW_W'(p);
    s.pitch_timed_out = pt;
    s.volume_reading = RAW_W'(v);
    s.volume_timed_out = vt;
    return s;
  endfunction

  // A distance that is mostly inside the playing range.
  function automatic int near_dist();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, DIST_LIMIT - 1);
    return $urandom_range(MIN_DIST, MAX_DIST);
  endfunction

  // A reading that must be rejected: timed out, or too far.
  task automatic bad_reading(output int raw, output logic tmo);
    if ($urandom_range(0, 1) == 0) begin
      raw = $urandom_range(0, 65535);
      tmo = 1'b1;
    end else begin
      raw = $urandom_range(DIST_LIMIT, 65535);
      tmo = 1'b0;
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == REG_DUAL_MODE) mdl_dual = val[0];
    else mdl_fail_limit = val;
  endtask

  // Wait until every request has been answered, then let the pipeline settle.
  task automatic wait_idle();
    while (reading_queue.size() > 0 || sample_valid || predicted_q.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Fill one phase with runs of well-formed readings, bad bursts and noise.
  task automatic queue_random_phase(int count);
    int   added;
    int   kind;
    int   len;
    int   p;
    int   v;
    logic pt;
    logic vt;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        len = $urandom_range(1, 16);
        repeat (len) begin
          p = near_dist();
          pt = 1'b0;
          v = near_dist();
          vt = 1'b0;
          if ($urandom_range(0, 7) == 0) bad_reading(p, pt);
          if ($urandom_range(0, 7) == 0) bad_reading(v, vt);
          reading_queue.push_back(make_pair(p, pt, v, vt));
        end
      end else if (kind < 8) begin
        // Bad readings in a row, sometimes long enough to reach a restart.
        len = $urandom_range(1, int'(mdl_fail_limit) + 3);
        kind = $urandom_range(0, 2);
        repeat (len) begin
          p = near_dist();
          pt = 1'b0;
          v = near_dist();
          vt = 1'b0;
          if (kind != 1) bad_reading(p, pt);
          if (kind != 0) bad_reading(v, vt);
          reading_queue.push_back(make_pair(p, pt, v, vt));
        end
      end else begin
        len = $urandom_range(1, 8);
        repeat (len)
          reading_queue.push_back(make_pair($urandom_range(0, 65535), $urandom_range(0, 1),
                                            $urandom_range(0, 65535), $urandom_range(0, 1)));
      end
      added += len;
    end
  endtask

  initial begin : stimulus
    int dual_list[8];
    int limit_list[8];
    dual_list  = '{1, 1, 0, 0, 1, 0, 1, 0};
    limit_list = '{0, 63, 0, 63, 1, 50, -1, -1};

    mdl_dual = 1'b0;
    mdl_fail_limit = FAIL_LIMIT_RESET;
    mdl_freq = longint'(MIN_FREQ) << FRAC_BITS;
    mdl_pitch_dist = '0;
    mdl_volume_dist = '0;
    mdl_volume = LEVEL_RESET;
    mdl_mute = 1'b1;
    mdl_pitch_fails = '0;
    mdl_volume_fails = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-sensor mode at reset settings, range edges and rejects.
    @(negedge clk);
    reading_queue.push_back(make_pair(MIN_DIST, 0, 0, 0));
    reading_queue.push_back(make_pair(MAX_DIST, 0, 65535, 1));
    reading_queue.push_back(make_pair(0, 0, 0, 0));
    reading_queue.push_back(make_pair(DIST_LIMIT - 1, 0, 0, 0));
    reading_queue.push_back(make_pair(DIST_LIMIT, 0, 0, 0));
    reading_queue.push_back(make_pair(65535, 1, 0, 0));
    reading_queue.push_back(make_pair(240, 0, 0, 0));
    wait_idle();

    // Directed: dual-sensor mode with a small fail limit to force restarts.
    write_reg(REG_DUAL_MODE, CFG_DATA_W'(1));
    write_reg(REG_FAIL_LIMIT, CFG_DATA_W'(2));
    @(negedge clk);
    reading_queue.push_back(make_pair(MIN_DIST - 1, 0, MAX_DIST + 1, 0));
    reading_queue.push_back(make_pair(100, 0, MIN_DIST, 0));
    reading_queue.push_back(make_pair(MAX_DIST + 1, 0, MAX_DIST, 0));
    reading_queue.push_back(make_pair(65535, 0, 0, 1));
    reading_queue.push_back(make_pair(0, 1, 4096, 0));
    reading_queue.push_back(make_pair(65535, 1, 65535, 1));
    reading_queue.push_back(make_pair(200, 0, 200, 0));
    reading_queue.push_back(make_pair(65535, 1, 65535, 1));
    reading_queue.push_back(make_pair(4096, 0, 4096, 0));
    reading_queue.push_back(make_pair(MAX_DIST, 0, MIN_DIST, 0));
    reading_queue.push_back(make_pair(MIN_DIST, 0, 65535, 0));
    reading_queue.push_back(make_pair(100, 0, 100, 0));
    wait_idle();

    // Random phases over a spread of register settings.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DUAL_MODE, CFG_DATA_W'(dual_list[ph]));
      write_reg(REG_FAIL_LIMIT, (limit_list[ph] < 0) ? CFG_DATA_W'($urandom_range(0, 63))
                                                     : CFG_DATA_W'(limit_list[ph]));
      @(negedge clk);
      queue_random_phase(ITEMS_PER_PHASE);
      wait_idle();
    end

    if (predicted_q.size() > 0)
      report_error($sformatf("%0d results never arrived", predicted_q.size()));
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
